// ----- rtl/weighted_urgency_scheduler_macros.svh -----
// Assertion macros shared by the weighted urgency scheduler RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef WEIGHTED_URGENCY_SCHEDULER_MACROS_SVH
`define WEIGHTED_URGENCY_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WUS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WUS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/wus_pkg.sv -----
// Package of the weighted urgency scheduler: widths, opcodes, entry and state types.
// No dependencies; imported by the scheduler top level.
`default_nettype none

package wus_pkg;

   localparam int TARGETS    = 16;
   localparam int IDX_W      = $clog2(TARGETS);
   localparam int FRAC_W     = 16;
   localparam int URG_W      = 24 + FRAC_W;
   localparam int TOT_W      = 28 + FRAC_W;
   localparam int PRI_W      = 16;
   localparam int VIS_W      = 32;
   localparam int VTX_W      = 16;
   localparam int TIME_W     = 32;
   localparam int SUM_W      = 20;
   localparam int FAC_W      = 16;
   localparam int OP_W       = 4;
   localparam int TGT_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int MUL_W      = TIME_W + PRI_W;
   localparam int DIVD_W     = MUL_W + FRAC_W;
   localparam int DCNT_W     = $clog2(DIVD_W);
   localparam int GK_W       = $clog2(PRI_W);

   localparam logic [URG_W-1:0] URG_MAX = {URG_W{1'b1}};
   localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [PRI_W-1:0] PRI_MAX = {PRI_W{1'b1}};
   localparam logic [VIS_W-1:0] VIS_MAX = {VIS_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR    = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 4'd0,
      OP_ADVANCE   = 4'd1,
      OP_VISIT     = 4'd2,
      OP_EMERGENCY = 4'd3,
      OP_INC_PRIO  = 4'd4,
      OP_CLR_PRIO  = 4'd5,
      OP_CLR_VISIT = 4'd6,
      OP_DELETE    = 4'd7,
      OP_FIND      = 4'd8,
      OP_SET_TIME  = 4'd9
   } opcode_type;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic [PRI_W-1:0] prio;
      logic [URG_W-1:0] urgency;
      logic [VIS_W-1:0] visits;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_G_READ,
      ST_G_EVAL,
      ST_G_STEP,
      ST_G_END,
      ST_READ,
      ST_EVAL,
      ST_MUL,
      ST_DLOAD,
      ST_DIV,
      ST_APPLY,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/wus_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; holds the scheduler's target table.
`default_nettype none

module wus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/weighted_urgency_scheduler.sv -----
// Top level of the weighted urgency scheduler: sequencer, divider, GCD unit and result register.
// Depends on wus_pkg, wus_ram and weighted_urgency_scheduler_macros.svh.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_stall  opcode, target, vertex, priority, time
//   rsp_     out        rsp_valid/rsp_stall  best target, totals, addressed target
//   csr_     in         csr_write_enable     normalize_enable, emergency_factor
//
// Every item walks all table entries in the RAM, each through read, evaluate and write states.
// An advance with a nonzero priority sum also passes each used entry through the multiplier and
// the restoring divider, which yields one quotient bit a cycle.
// An emergency with normalisation first walks the table through the binary GCD unit.
// Reset is synchronous and empties the table at once through the in-use flags.
// A finished result waits in the output register; the next transfer is accepted meanwhile.
`default_nettype none
`include "weighted_urgency_scheduler_macros.svh"

module weighted_urgency_scheduler
   import wus_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [OP_W-1:0]       req_opcode,
   input  wire logic [TGT_W-1:0]      req_target,
   input  wire logic [VTX_W-1:0]      req_vertex,
   input  wire logic [PRI_W-1:0]      req_priority_req,
   input  wire logic [TIME_W-1:0]     req_time_now,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_best_found,
   output logic [TGT_W-1:0]           rsp_best_target,
   output logic [URG_W-1:0]           rsp_best_urgency,
   output logic [TOT_W-1:0]           rsp_urgency_total,
   output logic                       rsp_hit,
   output logic [TGT_W-1:0]           rsp_hit_target,
   output logic [PRI_W-1:0]           rsp_target_priority,
   output logic [VIS_W-1:0]           rsp_target_visits,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   state_type state_ff, state_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [TGT_W-1:0]  target_ff, target_in;
   logic [VTX_W-1:0]  vertex_ff, vertex_in;
   logic [PRI_W-1:0]  prio_req_ff, prio_req_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [TARGETS-1:0] used_ff, used_in;
   logic               normalize_ff, normalize_in;
   logic [FAC_W-1:0]   factor_ff, factor_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TIME_W-1:0]  last_time_ff, last_time_in;
   logic [TOT_W-1:0]   last_total_ff, last_total_in;

   logic [TIME_W-1:0] diff_ff, diff_in;
   entry_type         cur_ff, cur_in;
   logic [MUL_W-1:0]  mul_ff, mul_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [SUM_W-1:0]  divisor_ff, divisor_in;

   logic [PRI_W-1:0] g_ff, g_in;
   logic             g_any_ff, g_any_in;
   logic             g_one_ff, g_one_in;
   logic [PRI_W-1:0] ga_ff, ga_in;
   logic [PRI_W-1:0] gb_ff, gb_in;
   logic [GK_W-1:0]  gk_ff, gk_in;
   logic [PRI_W-1:0] norm_ff, norm_in;

   logic             best_found_ff, best_found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [URG_W-1:0] best_urg_ff, best_urg_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic             fhit_ff, fhit_in;
   logic [IDX_W-1:0] fidx_ff, fidx_in;
   logic [PRI_W-1:0] cap_pri_ff, cap_pri_in;
   logic [VIS_W-1:0] cap_vis_ff, cap_vis_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [TGT_W-1:0] rsp_btgt_ff, rsp_btgt_in;
   logic [URG_W-1:0] rsp_burg_ff, rsp_burg_in;
   logic [TOT_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [TGT_W-1:0] rsp_htgt_ff, rsp_htgt_in;
   logic [PRI_W-1:0] rsp_pri_ff, rsp_pri_in;
   logic [VIS_W-1:0] rsp_vis_ff, rsp_vis_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;

   logic             req_accept;
   logic [IDX_W-1:0] tg_idx;
   logic             tg_valid;
   logic             tg_used;
   logic             idx_last;
   logic             used_i;
   logic             is_adv;
   logic             need_arith;
   logic             rsp_free;

   logic [SUM_W:0]   div_shift;
   logic [SUM_W:0]   div_diff;
   logic             div_ge;
   logic [URG_W-1:0] adv_inc;
   logic [URG_W:0]   adv_sum;
   logic [TOT_W:0]   tot_sum;
   logic [TIME_W-1:0] mul_a;

   assign req_accept = req_valid && !req_stall;
   assign tg_idx     = IDX_W'(target_ff);
   assign tg_valid   = 32'(target_ff) < 32'(TARGETS);
   assign tg_used    = tg_valid && used_ff[tg_idx];
   assign idx_last   = idx_ff == IDX_W'(TARGETS - 1);
   assign used_i     = used_ff[idx_ff];
   assign is_adv     = op_ff == OP_ADVANCE;
   assign rd_entry   = entry_type'(ram_rd_data);
   assign rsp_free   = !(rsp_valid_ff && rsp_stall);
   assign need_arith = used_i && ((is_adv && sum_ff != '0) ||
                       (op_ff == OP_EMERGENCY && tg_valid && idx_ff == tg_idx));

   wus_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TARGETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            if (op_ff == OP_EMERGENCY && tg_used && normalize_ff) state_in = ST_G_READ;
            else state_in = ST_READ;
         end
         ST_G_READ: state_in = ST_G_EVAL;
         ST_G_EVAL: begin
            if (used_i && !g_one_ff && g_any_ff && rd_entry.prio > PRI_W'(1)) begin
               state_in = ST_G_STEP;
            end else if (idx_last) begin
               state_in = ST_G_END;
            end else begin
               state_in = ST_G_READ;
            end
         end
         ST_G_STEP: begin
            if (ga_ff == gb_ff) state_in = idx_last ? ST_G_END : ST_G_READ;
         end
         ST_G_END: state_in = ST_READ;
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL:  state_in = need_arith ? ST_MUL : ST_WRITE;
         ST_MUL:   state_in = ST_DLOAD;
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (dcnt_ff == DCNT_W'(DIVD_W - 1)) state_in = ST_APPLY;
         end
         ST_APPLY: state_in = ST_WRITE;
         ST_WRITE: state_in = idx_last ? ST_DONE : ST_READ;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = cur_ff;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_START: begin
            ram_wr_en   = op_ff == OP_ADD && tg_valid && !tg_used;
            ram_wr_addr = tg_idx;
            ram_wr_data = {vertex_ff, prio_req_ff, {URG_W{1'b0}}, {VIS_W{1'b0}}};
         end
         ST_G_READ, ST_READ: ram_rd_en = 1'b1;
         ST_WRITE: ram_wr_en = used_i;
         default: ;
      endcase
   end

   always_comb begin
      mul_a     = is_adv ? diff_ff : TIME_W'(factor_ff);
      div_shift = {rem_ff, quo_ff[DIVD_W-1]};
      div_diff  = div_shift - {1'b0, divisor_ff};
      div_ge    = div_shift >= {1'b0, divisor_ff};
      adv_inc   = (|quo_ff[DIVD_W-1:URG_W]) ? URG_MAX : quo_ff[URG_W-1:0];
      adv_sum   = {1'b0, cur_ff.urgency} + {1'b0, adv_inc};
      tot_sum   = {1'b0, tot_ff} + (TOT_W + 1)'(cur_ff.urgency);
   end

   always_comb begin
      op_in         = op_ff;
      target_in     = target_ff;
      vertex_in     = vertex_ff;
      prio_req_in   = prio_req_ff;
      time_in       = time_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      normalize_in  = normalize_ff;
      factor_in     = factor_ff;
      sum_in        = sum_ff;
      last_time_in  = last_time_ff;
      last_total_in = last_total_ff;
      diff_in       = diff_ff;
      cur_in        = cur_ff;
      mul_in        = mul_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      divisor_in    = divisor_ff;
      g_in          = g_ff;
      g_any_in      = g_any_ff;
      g_one_in      = g_one_ff;
      ga_in         = ga_ff;
      gb_in         = gb_ff;
      gk_in         = gk_ff;
      norm_in       = norm_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_urg_in   = best_urg_ff;
      tot_in        = tot_ff;
      fhit_in       = fhit_ff;
      fidx_in       = fidx_ff;
      cap_pri_in    = cap_pri_ff;
      cap_vis_in    = cap_vis_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_btgt_in   = rsp_btgt_ff;
      rsp_burg_in   = rsp_burg_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_htgt_in   = rsp_htgt_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_vis_in    = rsp_vis_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NORMALIZE: normalize_in = csr_write_data[0];
            CSR_FACTOR:    factor_in    = csr_write_data[FAC_W-1:0];
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_opcode;
               target_in   = req_target;
               vertex_in   = req_vertex;
               prio_req_in = req_priority_req;
               time_in     = req_time_now;
            end
         end
         ST_START: begin
            idx_in        = '0;
            g_any_in      = 1'b0;
            g_one_in      = 1'b0;
            norm_in       = PRI_W'(1);
            best_found_in = 1'b0;
            best_idx_in   = '0;
            best_urg_in   = '0;
            tot_in        = '0;
            fhit_in       = 1'b0;
            fidx_in       = '0;
            case (op_ff)
               OP_ADD: begin
                  if (tg_valid && !tg_used) begin
                     used_in[tg_idx] = 1'b1;
                     sum_in = ({1'b0, sum_ff} + (SUM_W + 1)'(prio_req_ff) > {1'b0, SUM_MAX})
                            ? SUM_MAX : sum_ff + SUM_W'(prio_req_ff);
                  end
               end
               OP_ADVANCE: begin
                  diff_in      = time_ff - last_time_ff;
                  last_time_in = time_ff;
               end
               OP_CLR_PRIO: sum_in = '0;
               OP_DELETE: begin
                  used_in       = '0;
                  sum_in        = '0;
                  last_time_in  = '0;
                  last_total_in = '0;
                  normalize_in  = 1'b0;
               end
               OP_SET_TIME: last_time_in = time_ff;
               default: ;
            endcase
         end
         ST_G_EVAL: begin
            if (used_i && !g_one_ff) begin
               if (rd_entry.prio <= PRI_W'(1)) begin
                  g_one_in = 1'b1;
               end else if (!g_any_ff) begin
                  g_in     = rd_entry.prio;
                  g_any_in = 1'b1;
               end else begin
                  ga_in = g_ff;
                  gb_in = rd_entry.prio;
                  gk_in = '0;
               end
            end
            if (!(used_i && !g_one_ff && g_any_ff && rd_entry.prio > PRI_W'(1))) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_G_STEP: begin
            if (ga_ff == gb_ff) begin
               g_in   = PRI_W'(ga_ff << gk_ff);
               idx_in = idx_ff + IDX_W'(1);
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + GK_W'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_in = (ga_ff - gb_ff) >> 1;
            end else begin
               gb_in = (gb_ff - ga_ff) >> 1;
            end
         end
         ST_G_END: begin
            idx_in  = '0;
            norm_in = (!g_one_ff && g_any_ff && g_ff > PRI_W'(1)) ? g_ff : PRI_W'(1);
         end
         ST_EVAL: begin
            cur_in = rd_entry;
            if (used_i) begin
               case (op_ff)
                  OP_VISIT: begin
                     if (tg_valid && idx_ff == tg_idx) begin
                        cur_in.urgency = '0;
                        if (rd_entry.visits != VIS_MAX) begin
                           cur_in.visits = rd_entry.visits + VIS_W'(1);
                        end
                     end
                  end
                  OP_INC_PRIO: begin
                     if (tg_valid && idx_ff == tg_idx && rd_entry.prio != PRI_MAX) begin
                        cur_in.prio = rd_entry.prio + PRI_W'(1);
                        if (sum_ff != SUM_MAX) sum_in = sum_ff + SUM_W'(1);
                     end
                  end
                  OP_CLR_PRIO: begin
                     cur_in.prio    = '0;
                     cur_in.urgency = '0;
                  end
                  OP_CLR_VISIT: cur_in.visits = '0;
                  default: ;
               endcase
            end
         end
         ST_MUL: mul_in = mul_a * cur_ff.prio;
         ST_DLOAD: begin
            quo_in     = is_adv ? {mul_ff, {FRAC_W{1'b0}}} : DIVD_W'(mul_ff[TIME_W-1:0]);
            rem_in     = '0;
            dcnt_in    = '0;
            divisor_in = is_adv ? sum_ff : SUM_W'(norm_ff);
         end
         ST_DIV: begin
            quo_in  = {quo_ff[DIVD_W-2:0], div_ge};
            rem_in  = div_ge ? div_diff[SUM_W-1:0] : div_shift[SUM_W-1:0];
            dcnt_in = dcnt_ff + DCNT_W'(1);
         end
         ST_APPLY: begin
            if (is_adv) begin
               cur_in.urgency = adv_sum[URG_W] ? URG_MAX : adv_sum[URG_W-1:0];
            end else if (|quo_ff[DIVD_W-1:URG_W-FRAC_W]) begin
               cur_in.urgency = URG_MAX;
            end else begin
               cur_in.urgency = {quo_ff[URG_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            end
         end
         ST_WRITE: begin
            idx_in = idx_ff + IDX_W'(1);
            if (used_i) begin
               tot_in = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
               if (cur_ff.urgency > best_urg_ff) begin
                  best_found_in = 1'b1;
                  best_idx_in   = idx_ff;
                  best_urg_in   = cur_ff.urgency;
               end
            end
            if (op_ff == OP_FIND) begin
               if (used_i && !fhit_ff && cur_ff.vertex == vertex_ff) begin
                  fhit_in    = 1'b1;
                  fidx_in    = idx_ff;
                  cap_pri_in = cur_ff.prio;
                  cap_vis_in = cur_ff.visits;
               end
            end else if (tg_valid && idx_ff == tg_idx) begin
               cap_pri_in = cur_ff.prio;
               cap_vis_in = cur_ff.visits;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               if (is_adv) last_total_in = tot_ff;
               rsp_valid_in = 1'b1;
               rsp_found_in = best_found_ff;
               rsp_btgt_in  = TGT_W'(best_idx_ff);
               rsp_burg_in  = best_urg_ff;
               rsp_total_in = is_adv ? tot_ff : last_total_ff;
               if (op_ff == OP_FIND) begin
                  rsp_hit_in  = fhit_ff;
                  rsp_htgt_in = fhit_ff ? TGT_W'(fidx_ff) : '0;
                  rsp_pri_in  = fhit_ff ? cap_pri_ff : '0;
                  rsp_vis_in  = fhit_ff ? cap_vis_ff : '0;
               end else begin
                  rsp_hit_in  = tg_used;
                  rsp_htgt_in = target_ff;
                  rsp_pri_in  = tg_used ? cap_pri_ff : '0;
                  rsp_vis_in  = tg_used ? cap_vis_ff : '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         normalize_ff  <= 1'b0;
         factor_ff     <= FAC_W'(1);
         sum_ff        <= '0;
         last_time_ff  <= '0;
         last_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         normalize_ff  <= normalize_in;
         factor_ff     <= factor_in;
         sum_ff        <= sum_in;
         last_time_ff  <= last_time_in;
         last_total_ff <= last_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      target_ff     <= target_in;
      vertex_ff     <= vertex_in;
      prio_req_ff   <= prio_req_in;
      time_ff       <= time_in;
      idx_ff        <= idx_in;
      diff_ff       <= diff_in;
      cur_ff        <= cur_in;
      mul_ff        <= mul_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      divisor_ff    <= divisor_in;
      g_ff          <= g_in;
      g_any_ff      <= g_any_in;
      g_one_ff      <= g_one_in;
      ga_ff         <= ga_in;
      gb_ff         <= gb_in;
      gk_ff         <= gk_in;
      norm_ff       <= norm_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_urg_ff   <= best_urg_in;
      tot_ff        <= tot_in;
      fhit_ff       <= fhit_in;
      fidx_ff       <= fidx_in;
      cap_pri_ff    <= cap_pri_in;
      cap_vis_ff    <= cap_vis_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_btgt_ff   <= rsp_btgt_in;
      rsp_burg_ff   <= rsp_burg_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_htgt_ff   <= rsp_htgt_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_vis_ff    <= rsp_vis_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_found      = rsp_found_ff;
   assign rsp_best_target     = rsp_btgt_ff;
   assign rsp_best_urgency    = rsp_burg_ff;
   assign rsp_urgency_total   = rsp_total_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_hit_target      = rsp_htgt_ff;
   assign rsp_target_priority = rsp_pri_ff;
   assign rsp_target_visits   = rsp_vis_ff;

   // An accepted transfer always starts the sequencer on the next cycle.
   `WUS_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == ST_START, "accepted transfer did not start")

   // Delete all leaves no entry in use.
   `WUS_ASSERT_NEXT(a_delete_clears, clock, reset, state_ff == ST_START && op_ff == OP_DELETE, used_ff == '0, "delete all left entries in use")

   // The binary GCD operands never reach zero, otherwise the loop would not end.
   `WUS_ASSERT_NOW(a_gcd_nonzero, clock, reset, state_ff == ST_G_STEP, ga_ff != '0 && gb_ff != '0, "GCD operand reached zero")

   // A reported best target always carries a nonzero urgency, and only then.
   `WUS_ASSERT_NOW(a_best_consistent, clock, reset, rsp_valid_ff, rsp_found_ff == (rsp_burg_ff != '0), "best flag disagrees with urgency")

endmodule

`default_nettype wire
